// File: rtl/core/assert_macros.svh
// assertion helpers used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is asserted
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication, disabled while reset is asserted
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// File: rtl/core/bfba_pkg.sv
// ----------------------------------------------------------------------------
// bfba_pkg
// Types, constants and the index selection table of the bloom filter block.
// ----------------------------------------------------------------------------
package bfba_pkg;

  localparam int HASH_W      = 64;
  localparam int IDX_W       = 32;
  localparam int BIT_SEL_W   = 3;
  localparam int DIV_W       = IDX_W - BIT_SEL_W;
  localparam int DIV_CNT_W   = 5;
  localparam int NUM_SOURCES = 10;
  localparam int HC_W        = 4;
  localparam int BC_W        = 13;
  localparam int CFG_W       = 13;
  localparam int CFG_IDX_W   = 1;
  localparam int BYTE_W      = 8;

  localparam logic [CFG_IDX_W-1:0] REG_HASH_COUNT = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BYTE_COUNT = 1'd1;

  localparam logic [HC_W-1:0] HC_RESET = 4'd3;
  localparam logic [BC_W-1:0] BC_RESET = 13'd4096;

  localparam logic ACT_INSERT = 1'b0;
  localparam logic ACT_LOOKUP = 1'b1;

  typedef struct packed {
    logic              action;
    logic [HASH_W-1:0] hash_value;
  } in_item_t;

  typedef struct packed {
    logic present;
  } out_item_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_START,
    ST_MOD,
    ST_READ,
    ST_WRITE,
    ST_OUT
  } state_e;

  typedef struct packed {
    logic clr_step;
    logic load_item;
    logic mod_start;
    logic mod_step;
    logic probe_wr;
    logic out_push;
  } ctrl_cmd_t;

  typedef struct packed {
    logic clr_last;
    logic mod_last;
    logic probe_last;
    logic out_free;
  } dp_status_t;

  // 32-bit index built from little-endian hash bytes, least significant first
  function automatic logic [IDX_W-1:0] make_index(input logic [HASH_W-1:0] h,
                                                  input logic [HC_W-1:0]   which);
    logic [IDX_W-1:0] v;
    case (which)
      4'd0:    v = h[31:0];
      4'd1:    v = h[63:32];
      4'd2:    v = h[47:16];
      4'd3:    v = h[39:8];
      4'd4:    v = h[55:24];
      4'd5:    v = {h[7:0], h[63:40]};
      4'd6:    v = {h[15:0], h[63:48]};
      4'd7:    v = {h[23:0], h[63:56]};
      4'd8:    v = {h[55:48], h[39:32], h[23:16], h[7:0]};
      4'd9:    v = {h[63:56], h[47:40], h[31:24], h[15:8]};
      default: v = h[31:0];
    endcase
    return v;
  endfunction

endpackage

// File: rtl/core/bfba_stream_if.sv
// ----------------------------------------------------------------------------
// bfba_stream_if
// Valid/ready channel carrying one payload item per transfer.
// ----------------------------------------------------------------------------
interface bfba_stream_if #(
  parameter type T = logic
) ();

  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);

endinterface

// File: rtl/core/bfba_ram.sv
// ----------------------------------------------------------------------------
// bfba_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module bfba_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4096,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// File: rtl/core/bfba_ctrl.sv
// ----------------------------------------------------------------------------
// bfba_ctrl
// Sequencer: clearing pass, then per item one remainder, read and write per
// index, then the result.
// ----------------------------------------------------------------------------
module bfba_ctrl
  import bfba_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  input  dp_status_t status_i,
  output logic       in_ready_o,
  output ctrl_cmd_t  cmd_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_CLEAR: begin
        if (status_i.clr_last) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_valid_i) state_d = ST_START;
      end
      ST_START: state_d = ST_MOD;
      ST_MOD: begin
        if (status_i.mod_last) state_d = ST_READ;
      end
      ST_READ:  state_d = ST_WRITE;
      ST_WRITE: begin
        state_d = status_i.probe_last ? ST_OUT : ST_START;
      end
      ST_OUT: begin
        if (status_i.out_free) state_d = ST_IDLE;
      end
      default:  state_d = ST_CLEAR;
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      ST_CLEAR: cmd_o.clr_step = 1'b1;
      ST_IDLE: begin
        in_ready_o      = 1'b1;
        cmd_o.load_item = in_valid_i;
      end
      ST_START: cmd_o.mod_start = 1'b1;
      ST_MOD:   cmd_o.mod_step  = 1'b1;
      ST_READ:  ;
      ST_WRITE: cmd_o.probe_wr  = 1'b1;
      ST_OUT:   cmd_o.out_push  = status_i.out_free;
      default:  ;
    endcase
  end

endmodule

// File: rtl/core/bfba_dp.sv
// ----------------------------------------------------------------------------
// bfba_dp
// Datapath: config registers, item registers, bit-serial remainder unit,
// bit array memory and the result register.
// ----------------------------------------------------------------------------
module bfba_dp
  import bfba_pkg::*;
#(
  parameter int MAX_BYTES  = 4096,
  parameter int MAX_HASHES = 10
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0]     cfg_wdata_i,
  input  in_item_t             in_data_i,
  input  ctrl_cmd_t            cmd_i,
  output dp_status_t           status_o,
  input  logic                 out_ready_i,
  output logic                 out_valid_o,
  output out_item_t            out_data_o
);

  localparam int AW   = (MAX_BYTES > 1) ? $clog2(MAX_BYTES) : 1;
  localparam int NW   = $clog2(MAX_BYTES + 1);
  localparam int KMAX = (MAX_HASHES < NUM_SOURCES) ? MAX_HASHES : NUM_SOURCES;

  logic [HC_W-1:0] hash_count_q, hash_count_d;
  logic [BC_W-1:0] byte_count_q, byte_count_d;

  always_comb begin
    hash_count_d = hash_count_q;
    byte_count_d = byte_count_q;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_HASH_COUNT: hash_count_d = cfg_wdata_i[HC_W-1:0];
        REG_BYTE_COUNT: byte_count_d = cfg_wdata_i[BC_W-1:0];
        default:        ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hash_count_q <= HC_RESET;
      byte_count_q <= BC_RESET;
    end else begin
      hash_count_q <= hash_count_d;
      byte_count_q <= byte_count_d;
    end
  end

  // clamped index count and byte count
  logic [HC_W-1:0] k_eff;
  logic [31:0]     n_wide;
  logic [NW-1:0]   n_eff;

  always_comb begin
    if (hash_count_q == '0) begin
      k_eff = HC_W'(1);
    end else if (32'(hash_count_q) > 32'(KMAX)) begin
      k_eff = HC_W'(KMAX);
    end else begin
      k_eff = hash_count_q;
    end
    n_wide = 32'(byte_count_q);
    if (byte_count_q == '0) begin
      n_wide = 32'd1;
    end else if (n_wide > 32'(MAX_BYTES)) begin
      n_wide = 32'(MAX_BYTES);
    end
  end

  assign n_eff = n_wide[NW-1:0];

  // item registers
  logic [HASH_W-1:0] hash_q;
  logic              lookup_q;
  logic [HC_W-1:0]   probe_q;
  logic              all_q;

  // remainder unit
  logic [DIV_W-1:0]     div_q;
  logic [DIV_CNT_W-1:0] mcnt_q;
  logic [NW-1:0]        rem_q, rem_d;
  logic [BIT_SEL_W-1:0] bsel_q;
  logic [NW:0]          trial;
  logic [IDX_W-1:0]     index;

  // clearing pass and memory
  logic [AW-1:0]     clr_q;
  logic              ram_we;
  logic [AW-1:0]     ram_waddr;
  logic [BYTE_W-1:0] ram_wdata;
  logic [BYTE_W-1:0] ram_rdata;
  logic [BYTE_W-1:0] mask;
  logic              bit_hit;

  // result register
  logic out_valid_q;
  logic present_q;

  assign index = make_index(hash_q, probe_q);
  assign trial = {rem_q, div_q[DIV_W-1]};

  always_comb begin
    if (trial >= {1'b0, n_eff}) begin
      rem_d = NW'(trial - {1'b0, n_eff});
    end else begin
      rem_d = trial[NW-1:0];
    end
  end

  assign mask    = BYTE_W'(1) << bsel_q;
  assign bit_hit = (ram_rdata & mask) != '0;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_item) begin
      hash_q   <= in_data_i.hash_value;
      lookup_q <= in_data_i.action == ACT_LOOKUP;
    end
    if (cmd_i.mod_start) begin
      div_q  <= index[IDX_W-1:BIT_SEL_W];
      bsel_q <= index[BIT_SEL_W-1:0];
      rem_q  <= '0;
    end else if (cmd_i.mod_step) begin
      div_q <= {div_q[DIV_W-2:0], 1'b0};
      rem_q <= rem_d;
    end
    if (cmd_i.out_push) begin
      present_q <= all_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      probe_q     <= '0;
      all_q       <= 1'b1;
      mcnt_q      <= '0;
      clr_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.load_item) begin
        probe_q <= '0;
        all_q   <= 1'b1;
      end else if (cmd_i.probe_wr) begin
        probe_q <= probe_q + HC_W'(1);
        if (!bit_hit) all_q <= 1'b0;
      end
      if (cmd_i.mod_start) begin
        mcnt_q <= '0;
      end else if (cmd_i.mod_step) begin
        mcnt_q <= mcnt_q + DIV_CNT_W'(1);
      end
      if (cmd_i.clr_step) begin
        clr_q <= clr_q + AW'(1);
      end
      if (cmd_i.out_push) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // clearing writes zero; insert writes the byte back with the bit set
  always_comb begin
    if (cmd_i.clr_step) begin
      ram_we    = 1'b1;
      ram_waddr = clr_q;
      ram_wdata = '0;
    end else begin
      ram_we    = cmd_i.probe_wr && !lookup_q;
      ram_waddr = rem_q[AW-1:0];
      ram_wdata = ram_rdata | mask;
    end
  end

  bfba_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (MAX_BYTES)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (rem_q[AW-1:0]),
    .rdata_o (ram_rdata)
  );

  assign status_o.clr_last   = clr_q == AW'(MAX_BYTES - 1);
  assign status_o.mod_last   = mcnt_q == DIV_CNT_W'(DIV_W - 1);
  assign status_o.probe_last = probe_q == (k_eff - HC_W'(1));
  assign status_o.out_free   = !out_valid_q || out_ready_i;

  assign out_valid_o        = out_valid_q;
  assign out_data_o.present = present_q;

endmodule

// File: rtl/core/bloom_filter_bit_array_top.sv
// After reset the block runs a clearing pass over the bit array and takes no item until it is
// done. Each item then visits k indices, k being the clamped hash count: per index a setup
// step, a bit-serial remainder by the byte count, a memory read and a read-modify-write on
// the single byte-wide bit array RAM. The result goes to an output register, and the next item
// can be taken in the cycle after it is placed there. The reset hash count is three.
// Configuration must be written only while no item is in flight; the block does not enforce it.
// ----------------------------------------------------------------------------
// bloom_filter_bit_array_top
// Bloom filter over a byte-organized bit array with insert and lookup.
// ----------------------------------------------------------------------------
module bloom_filter_bit_array_top
  import bfba_pkg::*;
#(
  parameter int MAX_BYTES  = 4096,
  parameter int MAX_HASHES = 10
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0]     cfg_wdata_i,
  bfba_stream_if.sink          in_i,
  bfba_stream_if.source        out_o
);

  ctrl_cmd_t  cmd;
  dp_status_t status;
  in_item_t   in_data;
  out_item_t  out_data;

  assign in_data    = in_i.data;
  assign out_o.data = out_data;

  bfba_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .status_i   (status),
    .in_ready_o (in_i.ready),
    .cmd_o      (cmd)
  );

  bfba_dp #(
    .MAX_BYTES  (MAX_BYTES),
    .MAX_HASHES (MAX_HASHES)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_data_i   (in_data),
    .cmd_i       (cmd),
    .status_o    (status),
    .out_ready_i (out_o.ready),
    .out_valid_o (out_o.valid),
    .out_data_o  (out_data)
  );

endmodule

// File: rtl/core/bfba_checker.sv
// ----------------------------------------------------------------------------
// bfba_checker
// Port-level checks of the bloom filter top, attached by bind.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module bfba_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic in_valid_i,
  input logic in_ready_i,
  input logic out_valid_i,
  input logic out_ready_i,
  input logic out_present_i
);

  logic       in_xfer;
  logic       out_xfer;
  logic [1:0] pend_q, pend_d;

  assign in_xfer  = in_valid_i && in_ready_i;
  assign out_xfer = out_valid_i && out_ready_i;

  // items taken whose result has not been transferred yet
  always_comb begin
    pend_d = pend_q;
    if (in_xfer && !out_xfer) begin
      pend_d = pend_q + 2'd1;
    end else if (!in_xfer && out_xfer) begin
      pend_d = pend_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= '0;
    end else begin
      pend_q <= pend_d;
    end
  end

  `ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_i && !out_ready_i, out_valid_i)
  `ASSERT_NEXT(a_present_hold, clk_i, rst_ni, out_valid_i && !out_ready_i, $stable(out_present_i))
  `ASSERT_NEXT(a_one_at_a_time, clk_i, rst_ni, in_xfer, !in_ready_i)
  `ASSERT_IMPLIES(a_no_spurious, clk_i, rst_ni, out_valid_i, pend_q != 2'd0)
  `ASSERT_IMPLIES(a_no_overrun, clk_i, rst_ni, 1'b1, pend_q != 2'd3)

endmodule

bind bloom_filter_bit_array_top bfba_checker u_bfba_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (in_i.valid),
  .in_ready_i    (in_i.ready),
  .out_valid_i   (out_o.valid),
  .out_ready_i   (out_o.ready),
  .out_present_i (out_o.data.present)
);

// File: bench/bloom_filter_bit_array_top_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bloom_filter_bit_array_top_test
// Drives insert and lookup transfers into the bloom filter and compares each
// answer with a shadow bit array kept in the bench or a directed row's fixed
// answer. A directed table comes first, then random phases under new hash and byte counts.
// ----------------------------------------------------------------------------
module bloom_filter_bit_array_top_test;
  import bfba_pkg::*;

  localparam int FILTER_BYTES  = 4096;
  localparam int FILTER_HASHES = 10;
  localparam int DIRECTED_ROWS = 27;
  localparam int RANDOM_ITEMS  = 1950;
  localparam int PHASES        = 14;
  localparam int PHASE_ITEMS   = RANDOM_ITEMS / PHASES;
  localparam int POOL_DEPTH    = 512;
  localparam int DRAIN_SLACK   = 8;
  localparam int END_SLACK     = 400;
  localparam int CYCLE_LIMIT   = 4000000;

  typedef enum logic {
    ROW_ITEM,
    ROW_CFG
  } row_kind_e;

  typedef enum logic [1:0] {
    ANS_PREDICT,
    ANS_ABSENT,
    ANS_PRESENT
  } answer_e;

  typedef struct {
    row_kind_e             kind;
    logic [CFG_IDX_W-1:0]  reg_idx;
    logic [CFG_W-1:0]      reg_value;
    logic                  action;
    logic [HASH_W-1:0]     hash_value;
    answer_e               answer;
  } stim_row_t;

  typedef struct {
    logic              present;
    logic              action;
    logic [HASH_W-1:0] hash_value;
    int                serial;
  } answer_t;

  logic clk_i;
  logic rst_ni;
  logic cfg_we_i;
  logic [CFG_IDX_W-1:0] cfg_idx_i;
  logic [CFG_W-1:0] cfg_wdata_i;

  bfba_stream_if #(.T(in_item_t))  item_if ();
  bfba_stream_if #(.T(out_item_t)) answer_if ();

  bloom_filter_bit_array_top #(
    .MAX_BYTES  (FILTER_BYTES),
    .MAX_HASHES (FILTER_HASHES)
  ) uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_i        (item_if),
    .out_o       (answer_if)
  );

  // shadow copy of the filter
  logic [BYTE_W-1:0] shadow_bits [FILTER_BYTES];
  logic [HC_W-1:0] shadow_hash_count;
  logic [BC_W-1:0] shadow_byte_count;

  answer_t pending_answers [$];
  logic [HASH_W-1:0] hash_pool [$];
  stim_row_t directed_rows [DIRECTED_ROWS];

  bit steady_phase;
  int mismatch_count;
  int cycle_count;
  int sent_items;
  int insert_items;
  int lookup_items;
  int present_answers;
  int setting_count;

  // probe the k selected bits; inserts set them in order
  function automatic logic filter_probe(input logic act, input logic [HASH_W-1:0] h);
    logic [BYTE_W-1:0] hb [8];
    logic [IDX_W-1:0] idx;
    logic [31:0] nbits;
    logic [BYTE_W-1:0] mask;
    logic all_set;
    int k;
    int nbytes;
    int byte_no;
    for (int j = 0; j < 8; j++) begin
      hb[j] = h[8*j +: 8];
    end
    k = int'(shadow_hash_count);
    if (k < 1) k = 1;
    if (k > FILTER_HASHES) k = FILTER_HASHES;
    nbytes = int'(shadow_byte_count);
    if (nbytes < 1) nbytes = 1;
    if (nbytes > FILTER_BYTES) nbytes = FILTER_BYTES;
    nbits = 32'(nbytes * 8);
    all_set = 1'b1;
    for (int i = 0; i < k; i++) begin
      case (i)
        0: idx = {hb[3], hb[2], hb[1], hb[0]};
        1: idx = {hb[7], hb[6], hb[5], hb[4]};
        2: idx = {hb[5], hb[4], hb[3], hb[2]};
        3: idx = {hb[4], hb[3], hb[2], hb[1]};
        4: idx = {hb[6], hb[5], hb[4], hb[3]};
        5: idx = {hb[0], hb[7], hb[6], hb[5]};
        6: idx = {hb[1], hb[0], hb[7], hb[6]};
        7: idx = {hb[2], hb[1], hb[0], hb[7]};
        8: idx = {hb[6], hb[4], hb[2], hb[0]};
        default: idx = {hb[7], hb[5], hb[3], hb[1]};
      endcase
      idx = idx % nbits;
      byte_no = int'(idx / 8);
      mask = 8'h01 << idx[2:0];
      if ((shadow_bits[byte_no] & mask) == '0) all_set = 1'b0;
      if (act == ACT_INSERT) shadow_bits[byte_no] = shadow_bits[byte_no] | mask;
    end
    return all_set;
  endfunction

  task automatic report_mismatch(input string what);
    $display("mismatch at cycle %0d: %s", cycle_count, what);
    mismatch_count++;
  endtask

  // called at a falling edge, returns at a falling edge
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] value);
    cfg_we_i = 1'b1;
    cfg_idx_i = idx;
    cfg_wdata_i = value;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
    if (idx == REG_HASH_COUNT) shadow_hash_count = value[HC_W-1:0];
    else shadow_byte_count = value[BC_W-1:0];
    setting_count++;
  endtask

  // sender is held off until every answer is back
  task automatic wait_drained;
    item_if.valid = 1'b0;
    while (pending_answers.size() != 0) @(posedge clk_i);
    repeat (DRAIN_SLACK) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic send_item(input logic act, input logic [HASH_W-1:0] h, input answer_e ans);
    answer_t entry;
    logic predicted;
    while (!steady_phase && $urandom_range(0, 99) < 34) begin
      item_if.valid = 1'b0;
      @(negedge clk_i);
    end
    item_if.valid = 1'b1;
    item_if.data.action = act;
    item_if.data.hash_value = h;
    do @(posedge clk_i); while (!item_if.ready);
    predicted = filter_probe(act, h);
    entry.present = (ans == ANS_PREDICT) ? predicted : (ans == ANS_PRESENT);
    entry.action = act;
    entry.hash_value = h;
    entry.serial = sent_items;
    pending_answers.push_back(entry);
    sent_items++;
    if (act == ACT_INSERT) insert_items++;
    else lookup_items++;
    @(negedge clk_i);
  endtask

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("bloom_filter_bit_array_top_test NOT OK");
    $finish;
  end

  initial begin
    answer_if.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      answer_if.ready = steady_phase || ($urandom_range(0, 99) >= 34);
    end
  end

  always @(posedge clk_i) begin
    answer_t head;
    if (rst_ni && answer_if.valid && answer_if.ready) begin
      if (pending_answers.size() == 0) begin
        report_mismatch("answer transfer with nothing expected");
      end else begin
        head = pending_answers.pop_front();
        if (answer_if.data.present) present_answers++;
        if (answer_if.data.present !== head.present) begin
          report_mismatch($sformatf("item %0d %s hash %h: present %b, expected %b",
                                    head.serial, (head.action == ACT_LOOKUP) ? "lookup" : "insert",
                                    head.hash_value, answer_if.data.present, head.present));
        end
      end
    end
  end

  initial begin
    int r;
    logic [HASH_W-1:0] h;
    logic [HC_W-1:0] hc;
    logic [BC_W-1:0] bc;

    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_idx_i = REG_HASH_COUNT;
    cfg_wdata_i = '0;
    item_if.valid = 1'b0;
    item_if.data = '0;
    steady_phase = 1'b0;
    for (int i = 0; i < FILTER_BYTES; i++) shadow_bits[i] = '0;
    shadow_hash_count = HC_RESET;
    shadow_byte_count = BC_RESET;

    // reset counts first: k = 3 over the full array
    directed_rows[0]  = '{ROW_ITEM, REG_HASH_COUNT, 13'd0, ACT_LOOKUP, 64'h0, ANS_ABSENT};
    directed_rows[1]  = '{ROW_ITEM, REG_HASH_COUNT, 13'd0, ACT_LOOKUP, '1, ANS_ABSENT};
    // all three indices hit the same bit
    directed_rows[2]  = '{ROW_ITEM, REG_HASH_COUNT, 13'd0, ACT_INSERT, 64'h0, ANS_ABSENT};
    directed_rows[3]  = '{ROW_ITEM, REG_HASH_COUNT, 13'd0, ACT_LOOKUP, 64'h0, ANS_PRESENT};
    directed_rows[4]  = '{ROW_ITEM, REG_HASH_COUNT, 13'd0, ACT_INSERT, 64'h0, ANS_PRESENT};
    directed_rows[5]  = '{ROW_ITEM, REG_HASH_COUNT, 13'd0, ACT_INSERT, '1, ANS_ABSENT};
    directed_rows[6]  = '{ROW_ITEM, REG_HASH_COUNT, 13'd0, ACT_LOOKUP, '1, ANS_PRESENT};
    // zero hash count behaves as one
    directed_rows[7]  = '{ROW_CFG, REG_HASH_COUNT, 13'd0, ACT_INSERT, 64'h0, ANS_PREDICT};
    directed_rows[8]  = '{ROW_ITEM, REG_HASH_COUNT, 13'd0, ACT_INSERT,
                          64'h0123456789abcdef, ANS_PREDICT};
    directed_rows[9]  = '{ROW_ITEM, REG_HASH_COUNT, 13'd0, ACT_LOOKUP,
                          64'h0123456789abcdef, ANS_PRESENT};
    // hash count above ten saturates
    directed_rows[10] = '{ROW_CFG, REG_HASH_COUNT, 13'd15, ACT_INSERT, 64'h0, ANS_PREDICT};
    directed_rows[11] = '{ROW_ITEM, REG_HASH_COUNT, 13'd0, ACT_INSERT,
                          64'hfedcba9876543210, ANS_PREDICT};
    directed_rows[12] = '{ROW_ITEM, REG_HASH_COUNT, 13'd0, ACT_LOOKUP,
                          64'hfedcba9876543210, ANS_PRESENT};
    // zero byte count behaves as one byte
    directed_rows[13] = '{ROW_CFG, REG_BYTE_COUNT, 13'd0, ACT_INSERT, 64'h0, ANS_PREDICT};
    directed_rows[14] = '{ROW_ITEM, REG_HASH_COUNT, 13'd0, ACT_INSERT,
                          64'h8000000000000001, ANS_PREDICT};
    directed_rows[15] = '{ROW_ITEM, REG_HASH_COUNT, 13'd0, ACT_LOOKUP,
                          64'h0000000000000007, ANS_PREDICT};
    // byte count above the array size saturates
    directed_rows[16] = '{ROW_CFG, REG_BYTE_COUNT, 13'd8191, ACT_INSERT, 64'h0, ANS_PREDICT};
    directed_rows[17] = '{ROW_ITEM, REG_HASH_COUNT, 13'd0, ACT_INSERT,
                          64'haaaa5555aaaa5555, ANS_PREDICT};
    directed_rows[18] = '{ROW_ITEM, REG_HASH_COUNT, 13'd0, ACT_LOOKUP,
                          64'h5555aaaa5555aaaa, ANS_PREDICT};
    directed_rows[19] = '{ROW_CFG, REG_HASH_COUNT, 13'd10, ACT_INSERT, 64'h0, ANS_PREDICT};
    directed_rows[20] = '{ROW_CFG, REG_BYTE_COUNT, 13'd1, ACT_INSERT, 64'h0, ANS_PREDICT};
    directed_rows[21] = '{ROW_ITEM, REG_HASH_COUNT, 13'd0, ACT_INSERT,
                          64'h00000000ffffffff, ANS_PREDICT};
    directed_rows[22] = '{ROW_ITEM, REG_HASH_COUNT, 13'd0, ACT_LOOKUP, 64'h0, ANS_PREDICT};
    directed_rows[23] = '{ROW_CFG, REG_HASH_COUNT, 13'd1, ACT_INSERT, 64'h0, ANS_PREDICT};
    directed_rows[24] = '{ROW_CFG, REG_BYTE_COUNT, 13'd4096, ACT_INSERT, 64'h0, ANS_PREDICT};
    directed_rows[25] = '{ROW_ITEM, REG_HASH_COUNT, 13'd0, ACT_INSERT,
                          64'hffffffff00000000, ANS_PREDICT};
    directed_rows[26] = '{ROW_ITEM, REG_HASH_COUNT, 13'd0, ACT_LOOKUP,
                          64'h00000000ffffffff, ANS_PREDICT};

    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    foreach (directed_rows[i]) begin
      if (directed_rows[i].kind == ROW_CFG) begin
        wait_drained();
        write_reg(directed_rows[i].reg_idx, directed_rows[i].reg_value);
      end else begin
        send_item(directed_rows[i].action, directed_rows[i].hash_value, directed_rows[i].answer);
      end
    end

    for (int phase = 0; phase < PHASES; phase++) begin
      case (phase)
        0: begin hc = 4'd10; bc = 13'd4096; end
        1: begin hc = 4'd1;  bc = 13'd1;    end
        2: begin hc = 4'd0;  bc = 13'd8191; end
        3: begin hc = 4'd15; bc = 13'd0;    end
        default: begin
          hc = ($urandom_range(0, 3) == 0) ? HC_W'($urandom_range(0, 15)) :
                                             HC_W'($urandom_range(1, 10));
          case ($urandom_range(0, 2))
            0: bc = BC_W'($urandom_range(1, 64));
            1: bc = BC_W'($urandom_range(0, 8191));
            default: begin
              case ($urandom_range(0, 4))
                0: bc = 13'd0;
                1: bc = 13'd1;
                2: bc = 13'd4095;
                3: bc = 13'd4096;
                default: bc = 13'd8191;
              endcase
            end
          endcase
        end
      endcase
      wait_drained();
      // only the low nibble carries the hash count
      write_reg(REG_HASH_COUNT, {9'($urandom_range(0, 511)), hc});
      write_reg(REG_BYTE_COUNT, bc);
      steady_phase = (phase == 4);

      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (phase == 6 && n == PHASE_ITEMS / 2) wait_drained();
        r = $urandom_range(0, 99);
        if (r < 50 || hash_pool.size() == 0) begin
          h = {$urandom, $urandom};
          hash_pool.push_back(h);
          if (hash_pool.size() > POOL_DEPTH) void'(hash_pool.pop_front());
          send_item(ACT_INSERT, h, ANS_PREDICT);
        end else if (r < 60) begin
          send_item(ACT_INSERT, hash_pool[$urandom_range(0, hash_pool.size() - 1)],
                    ANS_PREDICT);
        end else if (r < 85) begin
          send_item(ACT_LOOKUP, hash_pool[$urandom_range(0, hash_pool.size() - 1)],
                    ANS_PREDICT);
        end else begin
          send_item(ACT_LOOKUP, {$urandom, $urandom}, ANS_PREDICT);
        end
      end
    end

    item_if.valid = 1'b0;
    steady_phase = 1'b0;
    while (pending_answers.size() != 0) @(posedge clk_i);
    repeat (END_SLACK) @(posedge clk_i);

    $display("covered %0d transfers: %0d inserts, %0d lookups, %0d answered present",
             sent_items, insert_items, lookup_items, present_answers);
    $display("across %0d register writes incl. zero and saturating counts, %0d mismatches",
             setting_count, mismatch_count);
    if (mismatch_count == 0) begin
      $display("bloom_filter_bit_array_top_test OK");
    end else begin
      $display("bloom_filter_bit_array_top_test NOT OK");
    end
    $finish;
  end

endmodule

// File: files.f
+incdir+rtl/core
rtl/core/bfba_pkg.sv
rtl/core/bfba_stream_if.sv
rtl/core/bfba_ram.sv
rtl/core/bfba_ctrl.sv
rtl/core/bfba_dp.sv
rtl/core/bloom_filter_bit_array_top.sv
rtl/core/bfba_checker.sv
bench/bloom_filter_bit_array_top_test.sv
